### src/shr_pkg.sv
// Shared constants, types and slot helpers for the snapshot history ring.
package shr_pkg;

  localparam int DEPTH        = 64;
  localparam int PAYLOAD_BITS = 64;
  localparam int SLOT_W       = $clog2(DEPTH);
  localparam int CNT_W        = 32;
  localparam int CLK_W        = 64;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);
  localparam logic [SLOT_W-1:0] TOP_SLOT  = SLOT_W'(64'h0000_0000_FFFF_FFFF % 64'(DEPTH));
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(DEPTH);

  localparam logic [1:0] REQ_CAPTURE = 2'd0;
  localparam logic [1:0] REQ_REWIND  = 2'd1;
  localparam logic [1:0] REQ_REPLAY  = 2'd2;
  localparam logic [1:0] REQ_CLEAR   = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  typedef struct packed {
    logic [CLK_W-1:0]        stamp;
    logic [PAYLOAD_BITS-1:0] pay;
  } shr_entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    shr_entry_t        data;
  } shr_wr_t;

  // Slot of pos - 1, given the slot of pos.
  function automatic logic [SLOT_W-1:0] slot_back(input logic [CNT_W-1:0] pos,
                                                  input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] res;
    if (pos == '0) begin
      res = TOP_SLOT;
    end else if (slot == '0) begin
      res = LAST_SLOT;
    end else begin
      res = slot - SLOT_W'(1);
    end
    return res;
  endfunction

  // Slot of pos_next = pos + 1, given the slot of pos.
  function automatic logic [SLOT_W-1:0] slot_fwd(input logic [CNT_W-1:0] pos_next,
                                                 input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] res;
    if (pos_next == '0 || slot == LAST_SLOT) begin
      res = '0;
    end else begin
      res = slot + SLOT_W'(1);
    end
    return res;
  endfunction

endpackage

### src/shr_hist_mem.sv
// Snapshot store with one write port and two write-first registered read ports.
module shr_hist_mem
  import shr_pkg::*;
(
  input  logic              clk,
  input  shr_wr_t           wr,
  input  logic [SLOT_W-1:0] rd_prev_slot,
  input  logic [SLOT_W-1:0] rd_cur_slot,
  output shr_entry_t        prev_q,
  output shr_entry_t        cur_q
);

  shr_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.slot] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.slot == rd_prev_slot) begin
      prev_q <= wr.data;
    end else begin
      prev_q <= mem[rd_prev_slot];
    end
    if (wr.en && wr.slot == rd_cur_slot) begin
      cur_q <= wr.data;
    end else begin
      cur_q <= mem[rd_cur_slot];
    end
  end

endmodule

### src/snapshot_history_ring.sv
// Top level of the snapshot history ring: request decode, marks and result register.
//
// Each input request carries an operation in in_tuser (capture, rewind, replay
// or clear) and, for a capture, a clock stamp and a state word in in_tdata.
// Every request yields exactly one result on the out_ channel: a status code
// in out_tuser and, in out_tdata, the restored entry (zero unless a rewind or
// replay succeeded) followed by the cursor, the rewind mark and the replay mark.
// The result is registered and appears in the cycle after the request is taken,
// and a new request can be taken every cycle while out_tready is high. The store
// keeps the entries at the cursor and just before it fetched in advance, so each
// request needs one pass through the decision logic and, for a capture, one write.
// Reset clears the cursor and both marks and holds in_tready low; the stored
// snapshots are left as they are and are never read before being written.
// While the receiver holds out_tready low with a result pending, in_tready
// drops and the result is held.
module snapshot_history_ring
  import shr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // current_clock[63:0], current_payload[127:64]
  input  logic [1:0]   in_tuser,  // req_type[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  // restored_clock[63:0], restored_payload[127:64], cursor_now[159:128],
  // oldest_mark[191:160], newest_mark[223:192]
  output logic [223:0] out_tdata,
  output logic [1:0]   out_tuser  // status[1:0]
);

  logic [CNT_W-1:0]  cursor_r, cursor_nxt;
  logic [CNT_W-1:0]  rewind_r, rewind_nxt;
  logic [CNT_W-1:0]  replay_r, replay_nxt;
  logic [CNT_W-1:0]  cursor_inc;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W-1:0] prev_slot;
  logic [SLOT_W-1:0] rd_prev_slot;
  logic              out_tvalid_r;
  logic [223:0]      out_tdata_r;
  logic [1:0]        out_tuser_r;
  logic [1:0]        status;
  logic [CLK_W-1:0]  rclk;
  logic [CLK_W-1:0]  rpay;
  logic              accept;
  logic [CLK_W-1:0]  in_clock;
  logic [CLK_W-1:0]  in_payload;
  shr_wr_t           wr;
  shr_entry_t        prev_q;
  shr_entry_t        cur_q;

  assign in_tready  = rst_n && (!out_tvalid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign in_clock   = in_tdata[63:0];
  assign in_payload = in_tdata[127:64];
  assign cursor_inc = cursor_r + CNT_W'(1);
  assign prev_slot  = slot_back(cursor_r, slot_r);

  always_comb begin
    cursor_nxt   = cursor_r;
    rewind_nxt   = rewind_r;
    replay_nxt   = replay_r;
    slot_nxt     = slot_r;
    status       = ST_DONE;
    rclk         = '0;
    rpay         = '0;
    wr.en        = 1'b0;
    wr.slot      = slot_r;
    wr.data.stamp = in_clock;
    wr.data.pay  = in_payload[PAYLOAD_BITS-1:0];
    if (accept) begin
      unique case (in_tuser)
        REQ_CAPTURE: begin
          if (cursor_r != '0 && prev_q.stamp == in_clock) begin
            status = ST_DUP;
          end else begin
            wr.en      = 1'b1;
            cursor_nxt = cursor_inc;
            slot_nxt   = slot_fwd(cursor_inc, slot_r);
            replay_nxt = cursor_inc;
            rewind_nxt = (cursor_inc < DEPTH_CNT) ? '0 : cursor_inc - DEPTH_CNT;
          end
        end
        REQ_REWIND: begin
          if (cursor_r <= rewind_r) begin
            status = ST_REFUSED;
          end else begin
            cursor_nxt = cursor_r - CNT_W'(1);
            slot_nxt   = prev_slot;
            rclk       = prev_q.stamp;
            rpay       = CLK_W'(prev_q.pay);
          end
        end
        REQ_REPLAY: begin
          if (cursor_r >= replay_r) begin
            status = ST_REFUSED;
          end else begin
            cursor_nxt = cursor_inc;
            slot_nxt   = slot_fwd(cursor_inc, slot_r);
            rclk       = cur_q.stamp;
            rpay       = CLK_W'(cur_q.pay);
          end
        end
        REQ_CLEAR: begin
          cursor_nxt = '0;
          rewind_nxt = '0;
          replay_nxt = '0;
          slot_nxt   = '0;
        end
        default: begin
          status = ST_DONE;
        end
      endcase
    end
  end

  assign rd_prev_slot = slot_back(cursor_nxt, slot_nxt);

  shr_hist_mem u_mem (
    .clk          (clk),
    .wr           (wr),
    .rd_prev_slot (rd_prev_slot),
    .rd_cur_slot  (slot_nxt),
    .prev_q       (prev_q),
    .cur_q        (cur_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r     <= '0;
      rewind_r     <= '0;
      replay_r     <= '0;
      slot_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      cursor_r <= cursor_nxt;
      rewind_r <= rewind_nxt;
      replay_r <= replay_nxt;
      slot_r   <= slot_nxt;
      if (accept) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_tdata_r <= {replay_nxt, rewind_nxt, cursor_nxt, rpay, rclk};
      out_tuser_r <= status;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tuser == REQ_CLEAR |=> cursor_r == '0 && rewind_r == '0 && replay_r == '0)
    else $error("clear request left a mark nonzero");

  a_rewind_steps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tuser == REQ_REWIND && cursor_r > rewind_r
    |=> cursor_r == $past(cursor_r) - CNT_W'(1))
    else $error("rewind did not step the cursor back by one");

  a_capture_marks: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> replay_r == cursor_r && cursor_r != rewind_r)
    else $error("capture left replay mark off the cursor");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("accepted request produced no result");

endmodule
